/* src/ltl_four_state_ca_row_step_defines.svh */
// assertion macros for the row stepper checker
`ifndef LTL_FOUR_STATE_CA_ROW_STEP_DEFINES_SVH
`define LTL_FOUR_STATE_CA_ROW_STEP_DEFINES_SVH
// a property that holds whenever reset is off
`define LTL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// an implication whose consequent is checked in the next cycle
`define LTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/ltl_pkg.sv */
// ----------------------------------------------------------------------------
// ltl_pkg
// shared constants and types of the four-state row stepper
// ----------------------------------------------------------------------------
package ltl_pkg;
	localparam int ROW_CELLS = 64;
	localparam int CNT_W = 5;
	localparam int CS_W = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	typedef logic [ROW_CELLS-1:0] row_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		REG_BORN_MIN    = 2'd0,
		REG_BORN_MAX    = 2'd1,
		REG_SURVIVE_MIN = 2'd2,
		REG_SURVIVE_MAX = 2'd3
	} reg_idx_t;

	// one window of five rows handed from front to back
	typedef struct packed {
		row_t a0;
		row_t a1;
		row_t a2;
		row_t a3;
		row_t a4;
		row_t ch;
		row_t cl;
	} win_t;

	typedef struct packed {
		cnt_t born_min;
		cnt_t born_max;
		cnt_t survive_min;
		cnt_t survive_max;
	} thr_t;
endpackage

/* src/ltl_front.sv */
// ----------------------------------------------------------------------------
// ltl_front
// row history and window forming; flags windows that give a result
// ----------------------------------------------------------------------------
module ltl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic          frame_start,
	input  ltl_pkg::row_t plane_high,
	input  ltl_pkg::row_t plane_low,
	output logic          win_valid,
	output ltl_pkg::win_t win
);
	import ltl_pkg::*;

	row_t hi_q [4];
	row_t lo_q [4];
	logic [2:0] filled_q;

	// a window exists once four rows sit in the history
	assign win_valid = take && !frame_start && (filled_q >= 3'd4);
	assign win.a0 = hi_q[0] & lo_q[0];
	assign win.a1 = hi_q[1] & lo_q[1];
	assign win.a2 = hi_q[2] & lo_q[2];
	assign win.a3 = hi_q[3] & lo_q[3];
	assign win.a4 = plane_high & plane_low;
	assign win.ch = hi_q[2];
	assign win.cl = lo_q[2];

	// history shift and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			for (int i = 0; i < 4; i++) begin
				hi_q[i] <= '0;
				lo_q[i] <= '0;
			end
		end else if (take) begin
			for (int i = 0; i < 3; i++) begin
				hi_q[i] <= hi_q[i+1];
				lo_q[i] <= lo_q[i+1];
			end
			hi_q[3] <= plane_high;
			lo_q[3] <= plane_low;
			if (frame_start) filled_q <= 3'd1;
			else if (filled_q < 3'd4) filled_q <= filled_q + 3'd1;
		end
	end
endmodule

/* src/ltl_back.sv */
// ----------------------------------------------------------------------------
// ltl_back
// per-cell adult count and next-state rule over one window
// ----------------------------------------------------------------------------
module ltl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ltl_pkg::win_t win,
	input  ltl_pkg::thr_t thr,
	output logic [1:0]    inflight,
	output logic          out_valid,
	output ltl_pkg::row_t out_high,
	output ltl_pkg::row_t out_low
);
	import ltl_pkg::*;

	// stage 1: per-column sums of the five rows
	logic [CS_W-1:0] col_sum_s1 [ROW_CELLS];
	row_t ch_s1, cl_s1;
	logic v_s1, v_s2;
	row_t nh_s2, nl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < ROW_CELLS; c++) begin
			col_sum_s1[c] <= CS_W'(win.a0[c]) + CS_W'(win.a1[c]) + CS_W'(win.a2[c])
				+ CS_W'(win.a3[c]) + CS_W'(win.a4[c]);
		end
		ch_s1 <= win.ch;
		cl_s1 <= win.cl;
	end

	// stage 2: wrapped horizontal sum and state rule
	always_ff @(posedge clk) begin
		for (int c = 0; c < ROW_CELLS; c++) begin
			logic [CNT_W-1:0] cnt;
			logic h, l;
			cnt = CNT_W'(col_sum_s1[(c+ROW_CELLS-2)%ROW_CELLS])
				+ CNT_W'(col_sum_s1[(c+ROW_CELLS-1)%ROW_CELLS])
				+ CNT_W'(col_sum_s1[c])
				+ CNT_W'(col_sum_s1[(c+1)%ROW_CELLS])
				+ CNT_W'(col_sum_s1[(c+2)%ROW_CELLS]);
			h = ch_s1[c];
			l = cl_s1[c];
			cnt = cnt - CNT_W'(h & l);
			case ({h, l})
				2'b00: begin
					nh_s2[c] <= 1'b0;
					nl_s2[c] <= (cnt >= thr.born_min) && (cnt <= thr.born_max);
				end
				2'b01: begin
					nh_s2[c] <= 1'b1;
					nl_s2[c] <= 1'b0;
				end
				2'b10: begin
					nh_s2[c] <= 1'b1;
					nl_s2[c] <= 1'b1;
				end
				default: begin
					nh_s2[c] <= (cnt >= thr.survive_min) && (cnt <= thr.survive_max);
					nl_s2[c] <= (cnt >= thr.survive_min) && (cnt <= thr.survive_max);
				end
			endcase
		end
	end

	// result words still in the two stages
	assign inflight = 2'(v_s1) + 2'(v_s2);
	assign out_valid = v_s2;
	assign out_high = nh_s2;
	assign out_low = nl_s2;
endmodule

/* src/ltl_fifo.sv */
// ----------------------------------------------------------------------------
// ltl_fifo
// result word queue with a count for flow control
// ----------------------------------------------------------------------------
module ltl_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ltl_pkg::row_t wr_high,
	input  ltl_pkg::row_t wr_low,
	input  logic          rd,
	output logic          empty,
	output logic [2:0]    count,
	output ltl_pkg::row_t rd_high,
	output ltl_pkg::row_t rd_low
);
	import ltl_pkg::*;

	row_t mh_q [FIFO_DEPTH];
	row_t ml_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign empty = (cnt_q == 3'd0);
	assign count = cnt_q;
	assign rd_high = mh_q[rp_q];
	assign rd_low = ml_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mh_q[wp_q] <= wr_high;
			ml_q[wp_q] <= wr_low;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

/* src/ltl_four_state_ca_row_step.sv */
// ----------------------------------------------------------------------------
// ltl_four_state_ca_row_step
// range-2 four-state larger-than-life row stepper
// ----------------------------------------------------------------------------
// One row word per cycle enters while full is low. A row that completes a
// five-row window gives the result word for the row two back, which goes
// through the two compute stages and then waits in a four-entry queue; full
// rises when queued words plus the words in the two compute stages reach
// four, so the sustained rate is one row per cycle while pop keeps up, and
// a held pop stalls the input once four words are pending.
module ltl_four_state_ca_row_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          frame_start,
	input  ltl_pkg::row_t plane_high,
	input  ltl_pkg::row_t plane_low,
	output logic          empty,
	input  logic          pop,
	output ltl_pkg::row_t next_high,
	output ltl_pkg::row_t next_low,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data
);
	import ltl_pkg::*;

	thr_t thr_q;
	logic take, win_valid, res_valid, rd;
	logic [1:0] inflight;
	win_t win;
	row_t res_h, res_l;
	logic [2:0] q_cnt;
	logic [2:0] pend;

	// results in flight plus queued must not exceed queue depth
	assign pend = q_cnt + 3'(inflight);
	assign full = (pend >= 3'(FIFO_DEPTH));
	assign take = push && !full;
	assign rd = pop && !empty;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.born_min <= 5'd3;
			thr_q.born_max <= 5'd5;
			thr_q.survive_min <= 5'd4;
			thr_q.survive_max <= 5'd9;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BORN_MIN:    thr_q.born_min <= cfg_data;
				REG_BORN_MAX:    thr_q.born_max <= cfg_data;
				REG_SURVIVE_MIN: thr_q.survive_min <= cfg_data;
				default:         thr_q.survive_max <= cfg_data;
			endcase
		end
	end

	ltl_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .frame_start(frame_start),
		.plane_high(plane_high), .plane_low(plane_low),
		.win_valid(win_valid), .win(win)
	);

	ltl_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(win_valid), .win(win), .thr(thr_q),
		.inflight(inflight), .out_valid(res_valid), .out_high(res_h), .out_low(res_l)
	);

	ltl_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(res_valid), .wr_high(res_h), .wr_low(res_l),
		.rd(rd), .empty(empty), .count(q_cnt), .rd_high(next_high), .rd_low(next_low)
	);
endmodule

/* src/ltl_checker.sv */
// ----------------------------------------------------------------------------
// ltl_checker
// port-level checks of the row stepper, bound to the top level
// ----------------------------------------------------------------------------
`include "ltl_four_state_ca_row_step_defines.svh"
module ltl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input logic          frame_start,
	input logic          empty,
	input logic          pop,
	input ltl_pkg::row_t next_high,
	input ltl_pkg::row_t next_low
);
	logic acc, quiet;
	logic acc_q1_q, acc_q2_q;

	// accepted input word and two registered copies of it, which make quiet
	assign acc = push && !full;
	assign quiet = !acc_q1_q && !acc_q2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q1_q <= 1'b0;
			acc_q2_q <= 1'b0;
		end else begin
			acc_q1_q <= acc;
			acc_q2_q <= acc_q1_q;
		end
	end

	// flow control flags are always known
	`LTL_ASSERT(a_known, clk, arst_n, !$isunknown({full, empty}), "full or empty unknown")
	// a frame start word never causes a result
	`LTL_ASSERT_NEXT(a_fs_none, clk, arst_n, acc && frame_start && empty && quiet, ##1 empty, "frame start gave a result")
	// a waiting word holds until popped
	`LTL_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(next_high) && $stable(next_low), "result word changed while waiting")
	// with nothing queued and nothing taken lately, no result appears
	`LTL_ASSERT_NEXT(a_idle, clk, arst_n, empty && quiet, empty, "result appeared from nothing")
endmodule

bind ltl_four_state_ca_row_step ltl_checker u_chk (.*);

/* bench/ltl_four_state_ca_row_step_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ltl_four_state_ca_row_step_tb
// self-checking bench for the range-2 four-state row stepper
// ----------------------------------------------------------------------------
// Rows are pushed as frames (two wrap rows, the grid, two wrap rows) with
// random content, plus stray frame starts and short broken frames. A model of
// the row window predicts each next-generation word; popped words are checked
// in order. Thresholds are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module ltl_four_state_ca_row_step_tb;
	import ltl_pkg::*;

	class row_step_scoreboard;
		logic [4:0] born_lo, born_hi, keep_lo, keep_hi;
		row_t hist_h[4], hist_l[4];
		int unsigned held;
		row_t want_h[$], want_l[$];
		int errors;

		function void init();
			born_lo = 3; born_hi = 5; keep_lo = 4; keep_hi = 9;
			foreach (hist_h[i]) begin
				hist_h[i] = '0;
				hist_l[i] = '0;
			end
			held = 0;
			errors = 0;
		endfunction

		function void set_threshold(reg_idx_t idx, logic [4:0] val);
			case (idx)
				REG_BORN_MIN: born_lo = val;
				REG_BORN_MAX: born_hi = val;
				REG_SURVIVE_MIN: keep_lo = val;
				REG_SURVIVE_MAX: keep_hi = val;
			endcase
		endfunction

		// take in one row; predict the middle row's next generation when window full
		function void note_row(logic fs, row_t ph, row_t pl);
			row_t adult[5];
			row_t nh, nl;
			int cnt;
			logic h, l;
			if (fs)
				held = 0;
			if (held >= 4) begin
				for (int r = 0; r < 4; r++)
					adult[r] = hist_h[r] & hist_l[r];
				adult[4] = ph & pl;
				nh = '0;
				nl = '0;
				for (int c = 0; c < ROW_CELLS; c++) begin
					cnt = 0;
					for (int r = 0; r < 5; r++)
						for (int d = -2; d <= 2; d++)
							cnt += adult[r][(c + d + ROW_CELLS) % ROW_CELLS];
					h = hist_h[2][c];
					l = hist_l[2][c];
					cnt -= (h & l);
					case ({h, l})
						2'b00: nl[c] = (cnt >= born_lo && cnt <= born_hi);
						2'b01: nh[c] = 1'b1;
						2'b10: begin
							nh[c] = 1'b1;
							nl[c] = 1'b1;
						end
						default: begin
							nh[c] = (cnt >= keep_lo && cnt <= keep_hi);
							nl[c] = nh[c];
						end
					endcase
				end
				want_h.push_back(nh);
				want_l.push_back(nl);
			end
			for (int r = 0; r < 3; r++) begin
				hist_h[r] = hist_h[r + 1];
				hist_l[r] = hist_l[r + 1];
			end
			hist_h[3] = ph;
			hist_l[3] = pl;
			if (held < 4)
				held++;
		endfunction

		function void check_word(row_t gh, row_t gl);
			if (want_h.size() == 0) begin
				$error("unexpected result word next_high=%h next_low=%h", gh, gl);
				errors++;
				return;
			end
			if (gh !== want_h[0]) begin
				$error("next_high expected %h actual %h", want_h[0], gh);
				errors++;
			end
			if (gl !== want_l[0]) begin
				$error("next_low expected %h actual %h", want_l[0], gl);
				errors++;
			end
			void'(want_h.pop_front());
			void'(want_l.pop_front());
		endfunction

		function int pending();
			return want_h.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic frame_start = 1'b0;
	row_t plane_high = '0;
	row_t plane_low = '0;
	logic empty;
	logic pop = 1'b0;
	row_t next_high, next_low;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	row_step_scoreboard sb;
	int unsigned cycles = 0;
	bit calm = 1'b0;
	bit hold_pop = 1'b0;
	int unsigned rows_sent = 0;

	localparam int unsigned CYCLE_LIMIT = 200000;

	ltl_four_state_ca_row_step dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.frame_start(frame_start), .plane_high(plane_high), .plane_low(plane_low),
		.empty(empty), .pop(pop), .next_high(next_high), .next_low(next_low),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** ltl_four_state_ca_row_step: FAILED **");
			$finish;
		end
	end

	// result side: check on accepted pops
	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_word(next_high, next_low);

	// receiver: random stall bursts, or a long hold when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pop) begin
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 6);
				pop <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic write_threshold(reg_idx_t idx, logic [4:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(idx, val);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// offer one row until accepted; sender gaps happen before offering
	task automatic send_row(logic fs, row_t ph, row_t pl);
		int n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
		push <= 1'b1;
		frame_start <= fs;
		plane_high <= ph;
		plane_low <= pl;
		do @(posedge clk); while (full);
		sb.note_row(fs, ph, pl);
		rows_sent++;
		@(negedge clk);
	endtask

	function automatic row_t rand_row();
		return {$urandom(), $urandom()};
	endfunction

	// a dense-ish row so that adults are common: bias planes toward ones
	function automatic row_t dense_row();
		return rand_row() | rand_row();
	endfunction

	// one toroidal frame of hgt grid rows
	task automatic send_frame(int hgt, int style);
		row_t gh[$], gl[$];
		row_t h, l;
		for (int r = 0; r < hgt; r++) begin
			case (style)
				0: begin h = rand_row(); l = rand_row(); end
				1: begin h = dense_row(); l = dense_row(); end
				default: begin h = rand_row() & rand_row(); l = rand_row(); end
			endcase
			gh.push_back(h);
			gl.push_back(l);
		end
		send_row(1'b1, gh[hgt - 2], gl[hgt - 2]);
		send_row(1'b0, gh[hgt - 1], gl[hgt - 1]);
		for (int r = 0; r < hgt; r++)
			send_row(1'b0, gh[r], gl[r]);
		send_row(1'b0, gh[0], gl[0]);
		send_row(1'b0, gh[1], gl[1]);
	endtask

	initial begin
		int hgt;
		sb = new();
		sb.init();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, all states, frame restart mid-fill, all-adult rows
		send_row(1'b1, '0, '0);
		send_row(1'b0, '1, '1);
		send_row(1'b0, '1, '0);
		send_row(1'b0, '0, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_row(1'b1, '1, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b1, '1, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b0, '1, '1);
		send_row(1'b0, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
		send_row(1'b0, '0, '0);
		send_row(1'b0, 64'h0000_0000_0000_0003, 64'hC000_0000_0000_0003);
		send_row(1'b0, '0, '0);
		drain();

		// phases over threshold settings, extremes and empty ranges included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_threshold(REG_BORN_MIN, 5'd0);
					write_threshold(REG_BORN_MAX, 5'd24);
					write_threshold(REG_SURVIVE_MIN, 5'd0);
					write_threshold(REG_SURVIVE_MAX, 5'd24);
				end
				1: begin
					write_threshold(REG_BORN_MIN, 5'd31);
					write_threshold(REG_BORN_MAX, 5'd0);
					write_threshold(REG_SURVIVE_MIN, 5'd24);
					write_threshold(REG_SURVIVE_MAX, 5'd31);
				end
				2: begin
					write_threshold(REG_BORN_MIN, 5'd10);
					write_threshold(REG_BORN_MAX, 5'd5);
					write_threshold(REG_SURVIVE_MIN, 5'd12);
					write_threshold(REG_SURVIVE_MAX, 5'd20);
				end
				5: begin
					write_threshold(REG_BORN_MIN, 5'd3);
					write_threshold(REG_BORN_MAX, 5'd5);
					write_threshold(REG_SURVIVE_MIN, 5'd4);
					write_threshold(REG_SURVIVE_MAX, 5'd9);
				end
				default: begin
					write_threshold(REG_BORN_MIN, 5'($urandom_range(0, 31)));
					write_threshold(REG_BORN_MAX, 5'($urandom_range(0, 31)));
					write_threshold(REG_SURVIVE_MIN, 5'($urandom_range(0, 31)));
					write_threshold(REG_SURVIVE_MAX, 5'($urandom_range(0, 31)));
				end
			endcase
			if (ph == 5)
				calm = 1'b1;
			for (int f = 0; f < 6; f++) begin
				hgt = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(3, 6);
				send_frame(hgt, $urandom_range(0, 2));
				// noise: short broken frame or lone rows
				if ($urandom_range(0, 2) == 0)
					for (int k = $urandom_range(1, 6); k > 0; k--)
						send_row(1'($urandom_range(0, 3) == 0), rand_row(), rand_row());
			end
			// long receiver hold while the sender keeps offering
			if (ph == 1) begin
				hold_pop = 1'b1;
				fork
					begin
						repeat (40) @(negedge clk);
						hold_pop = 1'b0;
					end
					begin
						send_frame(8, 1);
						push <= 1'b0;
					end
				join
			end
			drain();
		end

		drain();
		if (sb.errors == 0)
			$display("** ltl_four_state_ca_row_step: PASSED **");
		else
			$display("** ltl_four_state_ca_row_step: FAILED **");
		$finish;
	end
endmodule
